[rtl/lls_pkg.sv]
// ----------------------------------------------------------------------------
// lls_pkg: shared types and constants of the line lexer
// Token codes, lexer mode codes, the command word between the front and the
// back end, and the character class helpers.
// ----------------------------------------------------------------------------
package lls_pkg;

	// Token word width and length field width
	localparam int TOK_W = 12;
	localparam int LEN_W = 6;

	// Token codes
	localparam logic [TOK_W-1:0] TOK_LINE_END   = 12'd256;
	localparam logic [TOK_W-1:0] TOK_OTHER_BASE = 12'd512;
	localparam logic [TOK_W-1:0] TOK_COMPARE    = 12'd1280;
	localparam logic [TOK_W-1:0] TOK_COMMENT    = 12'd2051;
	localparam logic [TOK_W-1:0] TOK_WORD       = 12'd2305;
	localparam logic [TOK_W-1:0] TOK_NUMBER     = 12'd2306;
	localparam logic [TOK_W-1:0] TOK_STRING     = 12'd2307;

	// Lexer modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_HELD    = 3'd1;
	localparam logic [2:0] MODE_WORD    = 3'd2;
	localparam logic [2:0] MODE_NUMBER  = 3'd3;
	localparam logic [2:0] MODE_STRING  = 3'd4;
	localparam logic [2:0] MODE_COMMENT = 3'd5;

	// Characters with a role of their own
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_GREAT  = 8'h3E;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// Command queue depth
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// Command from front to back: a single token word, or a buffered token
	// dump (kind code, length, then the buffered characters)
	typedef struct packed {
		logic             is_dump;
		logic             is_last;
		logic [TOK_W-1:0] code;
		logic [LEN_W-1:0] len;
	} cmd_t;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// Characters that wait for the next one before they are decided
	function automatic logic is_holdable(input logic [7:0] c);
		return (c == CH_SLASH) || (c == CH_EQUAL) || (c == CH_BANG) ||
			(c == CH_LESS) || (c == CH_GREAT);
	endfunction

	// Characters that give a plain single code when lexed from idle
	function automatic logic is_other(input logic [7:0] c);
		return !((c == CH_SPACE) || (c == CH_TAB) || is_holdable(c) ||
			(c == CH_QUOTE) || is_letter(c) || (c == CH_USCORE) || is_digit(c));
	endfunction

	function automatic logic [TOK_W-1:0] other_code(input logic [7:0] c);
		return TOK_OTHER_BASE | {6'd0, c[5:0]};
	endfunction

endpackage

[rtl/lls_ram.sv]
// ----------------------------------------------------------------------------
// lls_ram: generic single write port RAM with registered read
// One write and one read address per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module lls_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 54,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/lls_front.sv]
// ----------------------------------------------------------------------------
// lls_front: lexer front end
// Takes input characters, runs the lexer modes, writes token characters into
// the buffer RAM and issues one command per cycle while the queue has room.
// ----------------------------------------------------------------------------
module lls_front #(
	parameter int KEEP_CAP = 54,
	parameter int ADDR_W   = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,  // [7:0] ch, [8] has_char, rest zero
	input  logic              s_axis_tlast,  // end_of_line
	output logic              cmd_push,
	output lls_pkg::cmd_t     cmd,
	input  logic              cmd_full,
	input  logic              dump_done,
	output logic              buf_we,
	output logic [ADDR_W-1:0] buf_waddr,
	output logic [7:0]        buf_wdata
);
	import lls_pkg::*;

	logic [7:0]       ch_q;
	logic             char_pend_q;
	logic             eol_pend_q;
	logic [2:0]       mode_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       held_q;
	logic [2:0]       dcnt_q;

	logic [2:0]       mode_d;
	logic [LEN_W-1:0] len_d;
	logic [7:0]       held_d;
	logic             clr_char;
	logic             clr_eol;
	logic             dump_push;
	logic             accept;

	assign s_axis_tready = !char_pend_q && !eol_pend_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign buf_waddr     = len_q[ADDR_W-1:0];
	assign buf_wdata     = ch_q;

	// One lexer step per cycle unless stalled: character step, then line end
	always_comb begin
		logic room;
		logic buf_free;
		logic cont;
		room      = len_q < LEN_W'(KEEP_CAP);
		buf_free  = (dcnt_q == 3'd0);
		cont      = 1'b0;
		mode_d    = mode_q;
		len_d     = len_q;
		held_d    = held_q;
		clr_char  = 1'b0;
		clr_eol   = 1'b0;
		dump_push = 1'b0;
		cmd_push  = 1'b0;
		cmd       = '0;
		buf_we    = 1'b0;
		if (char_pend_q) begin
			unique case (mode_q) inside
				MODE_HELD: begin
					if (!cmd_full) begin
						cmd_push = 1'b1;
						mode_d   = MODE_IDLE;
						if ((held_q == CH_SLASH) && (ch_q == CH_SLASH)) begin
							cmd.code    = TOK_COMMENT;
							cmd.is_last = !eol_pend_q;
							mode_d      = MODE_COMMENT;
							clr_char    = 1'b1;
						end else if ((held_q != CH_SLASH) && (ch_q == CH_EQUAL)) begin
							cmd.code    = TOK_COMPARE;
							cmd.is_last = !eol_pend_q;
							clr_char    = 1'b1;
						end else begin
							// held char goes out, current char is lexed again from idle
							cmd.code    = other_code(held_q);
							cmd.is_last = !eol_pend_q && !is_other(ch_q);
						end
					end
				end
				MODE_WORD, MODE_NUMBER: begin
					if (mode_q == MODE_WORD) begin
						cont = is_letter(ch_q) || is_digit(ch_q) || (ch_q == CH_USCORE) ||
							(ch_q == CH_DOT);
					end else begin
						cont = is_digit(ch_q) || (ch_q == CH_DOT);
					end
					if (cont) begin
						if (!room) begin
							clr_char = 1'b1;
						end else if (buf_free) begin
							buf_we   = 1'b1;
							len_d    = len_q + 1'b1;
							clr_char = 1'b1;
						end
					end else if (!cmd_full) begin
						cmd_push    = 1'b1;
						dump_push   = 1'b1;
						cmd.is_dump = 1'b1;
						cmd.code    = (mode_q == MODE_WORD) ? TOK_WORD : TOK_NUMBER;
						cmd.len     = len_q;
						cmd.is_last = !eol_pend_q && !is_other(ch_q);
						mode_d      = MODE_IDLE;
						len_d       = '0;
					end
				end
				MODE_STRING: begin
					if (ch_q == CH_QUOTE) begin
						if (!cmd_full) begin
							cmd_push    = 1'b1;
							dump_push   = 1'b1;
							cmd.is_dump = 1'b1;
							cmd.code    = TOK_STRING;
							cmd.len     = len_q;
							cmd.is_last = !eol_pend_q;
							mode_d      = MODE_IDLE;
							len_d       = '0;
							clr_char    = 1'b1;
						end
					end else if (!room) begin
						clr_char = 1'b1;
					end else if (buf_free) begin
						buf_we   = 1'b1;
						len_d    = len_q + 1'b1;
						clr_char = 1'b1;
					end
				end
				MODE_COMMENT: begin
					clr_char = 1'b1;
				end
				default: begin
					// idle: start a new token or give a plain code
					if ((ch_q == CH_SPACE) || (ch_q == CH_TAB)) begin
						clr_char = 1'b1;
					end else if (is_holdable(ch_q)) begin
						held_d   = ch_q;
						mode_d   = MODE_HELD;
						clr_char = 1'b1;
					end else if (ch_q == CH_QUOTE) begin
						mode_d   = MODE_STRING;
						len_d    = '0;
						clr_char = 1'b1;
					end else if (is_letter(ch_q) || (ch_q == CH_USCORE) || is_digit(ch_q)) begin
						if (buf_free) begin
							buf_we   = 1'b1;
							len_d    = LEN_W'(1);
							mode_d   = is_digit(ch_q) ? MODE_NUMBER : MODE_WORD;
							clr_char = 1'b1;
						end
					end else if (!cmd_full) begin
						cmd_push    = 1'b1;
						cmd.code    = other_code(ch_q);
						cmd.is_last = !eol_pend_q;
						mode_d      = MODE_IDLE;
						clr_char    = 1'b1;
					end
				end
			endcase
		end else if (eol_pend_q) begin
			unique case (mode_q) inside
				MODE_HELD: begin
					if (!cmd_full) begin
						cmd_push = 1'b1;
						cmd.code = other_code(held_q);
						mode_d   = MODE_IDLE;
					end
				end
				MODE_WORD, MODE_NUMBER, MODE_STRING: begin
					if (!cmd_full) begin
						cmd_push    = 1'b1;
						dump_push   = 1'b1;
						cmd.is_dump = 1'b1;
						cmd.len     = len_q;
						if (mode_q == MODE_WORD) begin
							cmd.code = TOK_WORD;
						end else if (mode_q == MODE_NUMBER) begin
							cmd.code = TOK_NUMBER;
						end else begin
							cmd.code = TOK_STRING;
						end
						mode_d = MODE_IDLE;
						len_d  = '0;
					end
				end
				default: begin
					if (!cmd_full) begin
						cmd_push    = 1'b1;
						cmd.code    = TOK_LINE_END;
						cmd.is_last = 1'b1;
						mode_d      = MODE_IDLE;
						len_d       = '0;
						clr_eol     = 1'b1;
					end
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pend_q <= 1'b0;
			eol_pend_q  <= 1'b0;
			mode_q      <= MODE_IDLE;
			len_q       <= '0;
			held_q      <= '0;
			dcnt_q      <= '0;
		end else begin
			mode_q <= mode_d;
			len_q  <= len_d;
			held_q <= held_d;
			if (accept) begin
				char_pend_q <= s_axis_tdata[8];
				eol_pend_q  <= s_axis_tlast;
			end else begin
				if (clr_char) begin
					char_pend_q <= 1'b0;
				end
				if (clr_eol) begin
					eol_pend_q <= 1'b0;
				end
			end
			// dumps issued but not yet read out by the back end
			if (dump_push && !dump_done) begin
				dcnt_q <= dcnt_q + 1'b1;
			end else if (!dump_push && dump_done) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	// Character payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= s_axis_tdata[7:0];
		end
	end

	// The buffer is never overwritten while a dump still reads it
	a_no_write_during_dump: assert property (@(posedge clk) disable iff (!arst_n)
		buf_we |-> (dcnt_q == 3'd0))
		else $error("buffer write while a dump is outstanding");

	a_done_has_dump: assert property (@(posedge clk) disable iff (!arst_n)
		dump_done |-> (dcnt_q != 3'd0))
		else $error("dump completion without an outstanding dump");

	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && (cmd.code == TOK_LINE_END) && !cmd.is_dump) |-> cmd.is_last)
		else $error("line end not marked last");

endmodule

[rtl/lls_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lls_cmd_fifo: command queue between lexer front and back end
// Small register FIFO with first-word-fall-through output.
// ----------------------------------------------------------------------------
module lls_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lls_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output lls_pkg::cmd_t rd_cmd,
	output logic          empty
);
	import lls_pkg::*;

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full   = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_cmd = mem_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue underflow");

endmodule

[rtl/lls_back.sv]
// ----------------------------------------------------------------------------
// lls_back: token emitter
// Pops commands and drives token words into the output register; a dump
// command gives the kind, the length and then the buffered characters.
// ----------------------------------------------------------------------------
module lls_back #(
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  lls_pkg::cmd_t     cmd_in,
	output logic              cmd_pop,
	output logic [ADDR_W-1:0] buf_raddr,
	input  logic [7:0]        buf_rdata,
	output logic              dump_done,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // [11:0] token, rest zero
	output logic              m_axis_tlast   // last
);
	import lls_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_LEN  = 2'd1;
	localparam logic [1:0] B_RD   = 2'd2;
	localparam logic [1:0] B_DATA = 2'd3;

	logic [1:0]       state_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q;
	logic             last_q;
	logic             out_valid_q;
	logic [TOK_W-1:0] out_tok_q;
	logic             out_last_q;

	logic             free;
	logic             load;
	logic [TOK_W-1:0] load_tok;
	logic             load_last;
	logic             final_char;

	assign free          = !out_valid_q || m_axis_tready;
	assign buf_raddr     = idx_q[ADDR_W-1:0];
	assign final_char    = (idx_q == (len_q - 1'b1));
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_tok_q};
	assign m_axis_tlast  = out_last_q;

	// Next output word
	always_comb begin
		load      = 1'b0;
		load_tok  = '0;
		load_last = 1'b0;
		cmd_pop   = 1'b0;
		dump_done = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!cmd_empty && free) begin
					cmd_pop   = 1'b1;
					load      = 1'b1;
					load_tok  = cmd_in.code;
					load_last = cmd_in.is_last && !cmd_in.is_dump;
				end
			end
			B_LEN: begin
				if (free) begin
					load      = 1'b1;
					load_tok  = {{(TOK_W-LEN_W){1'b0}}, len_q};
					load_last = last_q && (len_q == '0);
					dump_done = (len_q == '0);
				end
			end
			B_RD: begin
				load = 1'b0;
			end
			B_DATA: begin
				if (free) begin
					load      = 1'b1;
					load_tok  = {4'd0, buf_rdata};
					load_last = last_q && final_char;
					dump_done = final_char;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Sequencer and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (cmd_pop && cmd_in.is_dump) begin
						len_q   <= cmd_in.len;
						last_q  <= cmd_in.is_last;
						idx_q   <= '0;
						state_q <= B_LEN;
					end
				end
				B_LEN: begin
					if (free) begin
						state_q <= (len_q == '0) ? B_IDLE : B_RD;
					end
				end
				B_RD: begin
					state_q <= B_DATA;
				end
				B_DATA: begin
					if (free) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= final_char ? B_IDLE : B_RD;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_tok_q  <= load_tok;
			out_last_q <= load_last;
		end
	end

	a_data_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DATA) |-> ($past(state_q) == B_RD || $past(state_q) == B_DATA))
		else $error("character word without a preceding buffer read");

	a_dump_reads_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RD) |-> (idx_q < len_q))
		else $error("buffer read beyond token length");

endmodule

[rtl/line_lexer_token_stream.sv]
// ----------------------------------------------------------------------------
// line_lexer_token_stream: line lexer with a streaming token output
// Turns a character stream into token words: kind, length and characters of
// words, numbers and strings; single codes for operators, comparisons,
// comments, other characters and line ends.
//
// Usage:
//   Input transactions on s_axis carry one character (tdata[7:0]) with a
//   has_char flag (tdata[8]); tlast marks the end of the line. Output
//   transactions on m_axis carry one 12-bit token word in tdata[11:0];
//   tlast marks the final word caused by an input transaction.
//   A character is taken, then lexed in the following cycle; a new one is
//   taken only once the current one is fully lexed. Closing a token or
//   following a held character takes a further step, a line end may first
//   close an open token, and a step waits on a full command queue or on a
//   buffer readout. The first word of an item passes the input register,
//   the command queue and the output register. Single-code tokens and kind
//   and length words go out at one word per cycle while the receiver is
//   ready; each buffered character waits on the registered buffer read.
//   A 4-entry command queue decouples the lexer from the emitter, so input
//   keeps flowing while the receiver stalls until the queue fills.
//   Reset returns the lexer to idle with an empty queue; the token buffer
//   needs no clearing pass.
// ----------------------------------------------------------------------------
module line_lexer_token_stream #(
	parameter int MAX_TOKEN = 56
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] ch, [8] has_char, [15:9] zero
	input  logic        s_axis_tlast,   // end_of_line
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [11:0] token, [15:12] zero
	output logic        m_axis_tlast    // last
);
	import lls_pkg::*;

	// Kept token length saturates below 55 so every item stays within 60 words
	localparam int KEEP_CAP = (MAX_TOKEN < 54) ? MAX_TOKEN : 54;
	localparam int ADDR_W   = (KEEP_CAP > 1) ? $clog2(KEEP_CAP) : 1;

	cmd_t              f_cmd;
	cmd_t              b_cmd;
	logic              f_push;
	logic              q_full;
	logic              q_empty;
	logic              b_pop;
	logic              dump_done;
	logic              buf_we;
	logic [ADDR_W-1:0] buf_waddr;
	logic [7:0]        buf_wdata;
	logic [ADDR_W-1:0] buf_raddr;
	logic [7:0]        buf_rdata;

	// Front end: lexer modes and buffer writes
	lls_front #(
		.KEEP_CAP (KEEP_CAP),
		.ADDR_W   (ADDR_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cmd_push      (f_push),
		.cmd           (f_cmd),
		.cmd_full      (q_full),
		.dump_done     (dump_done),
		.buf_we        (buf_we),
		.buf_waddr     (buf_waddr),
		.buf_wdata     (buf_wdata)
	);

	// Command queue
	lls_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wr_cmd (f_cmd),
		.full   (q_full),
		.pop    (b_pop),
		.rd_cmd (b_cmd),
		.empty  (q_empty)
	);

	// Token character buffer
	lls_ram #(
		.WIDTH  (8),
		.DEPTH  (KEEP_CAP),
		.ADDR_W (ADDR_W)
	) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	// Back end: token word emitter
	lls_back #(
		.ADDR_W (ADDR_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_empty     (q_empty),
		.cmd_in        (b_cmd),
		.cmd_pop       (b_pop),
		.buf_raddr     (buf_raddr),
		.buf_rdata     (buf_rdata),
		.dump_done     (dump_done),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[dv/lexer_token_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer_token_checker: token stream predictor and comparator
// Watches both stream channels of the line lexer. Each accepted character
// transaction is run through a local lexer model that queues the token words
// it must cause. Each accepted output word is checked against the oldest one.
// ----------------------------------------------------------------------------
module lexer_token_checker #(
	parameter int MAX_TOKEN = 56
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] ch, [8] has_char, [15:9] zero
	input  logic        s_axis_tlast,   // end_of_line
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // [11:0] token, [15:12] zero
	input  logic        m_axis_tlast,   // last
	output int          mismatch_count,
	output int          tokens_pending,
	output int          words_checked
);
	import lls_pkg::*;

	// Kept length saturates here
	localparam int KEEP_CAP  = (MAX_TOKEN < 54) ? MAX_TOKEN : 54;
	localparam int ITEM_CAP  = 60;

	typedef struct packed {
		logic [TOK_W-1:0] token;
		logic             last;
	} token_word_t;

	// Lexer model state
	logic [2:0]       lex_state;
	logic [7:0]       tok_buf [0:55];
	logic [LEN_W-1:0] tok_len;
	logic [7:0]       pend_char;

	logic [TOK_W-1:0] item_words [$];
	token_word_t      expected_words [$];
	int               errs = 0;
	int               checked = 0;

	function automatic bit letter_char(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic bit digit_char(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Single-character code: base plus the low six bits
	function automatic logic [TOK_W-1:0] glyph_code(input logic [7:0] c);
		return TOK_OTHER_BASE + {6'd0, c[5:0]};
	endfunction

	task emit(input logic [TOK_W-1:0] w);
		if (item_words.size() < ITEM_CAP)
			item_words = {item_words, w};
	endtask

	task keep_char(input logic [7:0] c);
		if (tok_len < KEEP_CAP) begin
			tok_buf[tok_len] = c;
			tok_len = tok_len + 1'b1;
		end
	endtask

	// Kind code, length, then the buffered bytes
	task flush_token(input logic [TOK_W-1:0] kind);
		int k;
		emit(kind);
		emit({6'd0, tok_len});
		for (k = 0; k < tok_len; k++)
			emit({4'd0, tok_buf[k]});
		tok_len = '0;
		lex_state = MODE_IDLE;
	endtask

	// Character seen with no token in progress
	task lex_fresh(input logic [7:0] c);
		lex_state = MODE_IDLE;
		tok_len = '0;
		if (c == CH_SLASH || c == CH_EQUAL || c == CH_BANG || c == CH_LESS ||
			c == CH_GREAT) begin
			pend_char = c;
			lex_state = MODE_HELD;
		end else if (c == CH_QUOTE) begin
			lex_state = MODE_STRING;
		end else if (letter_char(c) || c == CH_USCORE) begin
			lex_state = MODE_WORD;
			keep_char(c);
		end else if (digit_char(c)) begin
			lex_state = MODE_NUMBER;
			keep_char(c);
		end else if (c != CH_SPACE && c != CH_TAB) begin
			emit(glyph_code(c));
		end
	endtask

	task lex_char(input logic [7:0] c);
		case (lex_state)
			MODE_HELD: begin
				lex_state = MODE_IDLE;
				if (pend_char == CH_SLASH && c == CH_SLASH) begin
					emit(TOK_COMMENT);
					lex_state = MODE_COMMENT;
				end else if (pend_char != CH_SLASH && c == CH_EQUAL) begin
					emit(TOK_COMPARE);
				end else begin
					emit(glyph_code(pend_char));
					lex_fresh(c);
				end
			end
			MODE_WORD: begin
				if (letter_char(c) || digit_char(c) || c == CH_USCORE || c == CH_DOT) begin
					keep_char(c);
				end else begin
					flush_token(TOK_WORD);
					lex_fresh(c);
				end
			end
			MODE_NUMBER: begin
				if (digit_char(c) || c == CH_DOT) begin
					keep_char(c);
				end else begin
					flush_token(TOK_NUMBER);
					lex_fresh(c);
				end
			end
			MODE_STRING: begin
				if (c == CH_QUOTE)
					flush_token(TOK_STRING);
				else
					keep_char(c);
			end
			MODE_COMMENT: begin
			end
			default: begin
				lex_fresh(c);
			end
		endcase
	endtask

	// Line end closes whatever is open, then the line end code
	task close_line();
		case (lex_state)
			MODE_HELD:   emit(glyph_code(pend_char));
			MODE_WORD:   flush_token(TOK_WORD);
			MODE_NUMBER: flush_token(TOK_NUMBER);
			MODE_STRING: flush_token(TOK_STRING);
			default: begin
			end
		endcase
		emit(TOK_LINE_END);
		lex_state = MODE_IDLE;
		tok_len = '0;
	endtask

	// Compare output words, then predict from the input transaction
	always @(posedge clk or negedge arst_n) begin : watch
		token_word_t want;
		int          k;
		if (!arst_n) begin
			lex_state = MODE_IDLE;
			tok_len = '0;
			pend_char = '0;
			expected_words.delete();
			mismatch_count <= 0;
			tokens_pending <= 0;
			words_checked <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				checked++;
				if (expected_words.size() == 0) begin
					errs++;
					$display("%0t: unexpected token word: expected none, actual tdata %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
				end else begin
					want = expected_words.pop_front();
					if (m_axis_tdata !== {4'd0, want.token}) begin
						errs++;
						$display("%0t: token mismatch: expected %0d, actual tdata %h",
							$time, want.token, m_axis_tdata);
					end
					if (m_axis_tlast !== want.last) begin
						errs++;
						$display("%0t: last mismatch on token %0d: expected %b, actual %b",
							$time, want.token, want.last, m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				item_words.delete();
				if (s_axis_tdata[8])
					lex_char(s_axis_tdata[7:0]);
				if (s_axis_tlast)
					close_line();
				for (k = 0; k < item_words.size(); k++) begin
					want.token = item_words[k];
					want.last = (k == item_words.size() - 1);
					expected_words = {expected_words, want};
				end
			end
			mismatch_count <= errs;
			tokens_pending <= expected_words.size();
			words_checked <= checked;
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: line lexer token stream testbench
// Drives source lines into the lexer: a directed set of corner cases, then
// random lines built from word, number, string, comparison, comment and noise
// fragments, with random gaps and back-pressure. The checker beside the block
// predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import lls_pkg::*;

	localparam int NUM_ITEMS = 330;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'd0;   // [7:0] ch, [8] has_char, [15:9] zero
	logic        s_axis_tlast = 1'b0;    // end_of_line
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [11:0] token, [15:12] zero
	logic        m_axis_tlast;           // last

	int          mismatch_count;
	int          tokens_pending;
	int          words_checked;
	int          items_sent = 0;
	int          lines_sent = 0;
	int unsigned rx_wait = 0;
	bit          rx_calm = 1'b0;
	bit          tx_calm = 1'b0;
	logic [7:0]  line_buf [$];

	line_lexer_token_stream dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	lexer_token_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.tokens_pending (tokens_pending),
		.words_checked  (words_checked)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Token sink: random stall after each transaction, calm stretches now and then
	always @(posedge clk) begin : token_sink
		int unsigned hold;
		if (m_axis_tvalid && m_axis_tready) begin
			hold = rx_calm ? 0 : $urandom_range(0, 8);
			if ($urandom_range(0, 47) == 0)
				rx_calm <= !rx_calm;
			rx_wait <= hold;
			m_axis_tready <= (hold == 0);
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			m_axis_tready <= (rx_wait == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// One character transaction, after a random gap
	task automatic send_item(input logic [7:0] c, input logic has, input logic eol);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, has, c};
		s_axis_tlast  <= eol;
		do @(posedge clk); while (!s_axis_tready);
		if (has || eol)
			items_sent++;
	endtask

	// Send the buffered line; end of line on the last char or as an empty item
	task automatic send_line(input bit split_eol);
		int i;
		for (i = 0; i < line_buf.size(); i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(line_buf[i], 1'b1, !split_eol && (i == line_buf.size() - 1));
		end
		if (split_eol || line_buf.size() == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		line_buf.delete();
		lines_sent++;
	endtask

	// Add one byte at the end of the line being built
	task automatic append_byte(input logic [7:0] c);
		line_buf = {line_buf, c};
	endtask

	task automatic push_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			append_byte(s[i]);
	endtask

	// Stop sending until every predicted token word has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0) @(posedge clk);
	endtask

	// One random source fragment; mostly short, sometimes past the length cap
	task automatic add_fragment();
		int unsigned kind, n, k;
		logic [7:0]  c;
		string       word_set, ops;
		word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
		ops = "/=!<>";
		kind = $urandom_range(0, 9);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 62) : $urandom_range(0, 7);
		case (kind)
			0, 1: begin
				k = $urandom_range(0, 52);
				append_byte((k == 52) ? CH_USCORE : word_set[k]);
				repeat (n) append_byte(word_set[$urandom_range(0, 63)]);
			end
			2: begin
				append_byte(word_set[$urandom_range(52, 61)]);
				repeat (n) begin
					c = ($urandom_range(0, 4) == 0) ? CH_DOT : word_set[$urandom_range(52, 61)];
					append_byte(c);
				end
			end
			3: begin
				append_byte(CH_QUOTE);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					append_byte((c == CH_QUOTE) ? CH_SPACE : c);
				end
				if ($urandom_range(0, 7) != 0)
					append_byte(CH_QUOTE);
			end
			4: begin
				append_byte(ops[$urandom_range(1, 4)]);
				append_byte(CH_EQUAL);
			end
			5: begin
				append_byte(ops[$urandom_range(0, 4)]);
				append_byte(8'($urandom_range(0, 255)));
			end
			6: begin
				append_byte(CH_SLASH);
				append_byte(CH_SLASH);
				repeat (n) append_byte(8'($urandom_range(0, 255)));
			end
			7: begin
				append_byte($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
			end
			default: begin
				append_byte(8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty item, then a line end with no character
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// Word, number ended by a quote, string, comparisons, held char then word
		push_str("_Z9. 7.\"h\"==!x>=");
		send_line(1'b0);
		// Comment drops the rest of the line
		push_str("//q");
		send_line(1'b1);
		// Held character at the line end
		push_str(">");
		send_line(1'b0);
		// Unterminated string at the line end
		push_str("\"k");
		send_line(1'b0);
		// Tab and bytes at the extremes
		append_byte(CH_TAB);
		append_byte(8'hFF);
		append_byte(8'h80);
		append_byte(8'h00);
		send_line(1'b0);
		drain();

		// Random lines
		while (items_sent < NUM_ITEMS) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			if (lines_sent == 8) begin
				// token well past the length cap
				repeat (58) append_byte(8'h77);
				append_byte(CH_SPACE);
			end
			repeat ($urandom_range(1, 5)) begin
				add_fragment();
				if ($urandom_range(0, 1))
					append_byte(CH_SPACE);
			end
			send_line($urandom_range(0, 5) == 0);
			if (lines_sent % 9 == 4)
				drain();
		end

		drain();
		repeat (40) @(posedge clk);
		$display("run covered %0d character transactions over %0d lines", items_sent, lines_sent);
		$display("%0d token words compared against the lexer model", words_checked);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
